FILE: rtl/ppmenc_pkg.sv
package ppmenc_pkg;

   localparam int COMP_W       = 24;
   localparam int ROW_WIDTH_W  = 13;
   localparam int LINE_LIMIT_W = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int CHAR_W       = 16;
   localparam int BREAK_W      = 10;
   localparam int SLOT_W       = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LIMIT = 1'b1;

   localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RESET  = 13'd1;
   localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_RESET = 8'd65;

   localparam logic [SLOT_W-1:0] SLOT_RED  = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_BLUE = 2'd2;

   localparam logic [CHAR_W-1:0]  CHAR_SAT  = 16'hFFFF;
   localparam logic [BREAK_W-1:0] BREAK_SAT = 10'h3FF;

   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_ZERO    = 8'h30;
   localparam logic [7:0] BYTE_NINE    = 8'h39;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic [7:0] level;
      logic       newline;
   } queue_entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: rtl/ppmenc_front.sv
module ppmenc_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ppmenc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ppmenc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ppmenc_pkg::COMP_W-1:0]  req_component,
   input  ppmenc_pkg::queue_status_type          q_status,
   output logic                                  push,
   output ppmenc_pkg::queue_entry_type           push_entry
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = (COL_W + 1 > ppmenc_pkg::ROW_WIDTH_W) ? COL_W + 1
                                                               : ppmenc_pkg::ROW_WIDTH_W;

   logic [ppmenc_pkg::ROW_WIDTH_W-1:0]  row_width_ff, row_width_in;
   logic [ppmenc_pkg::LINE_LIMIT_W-1:0] line_limit_ff, line_limit_in;
   logic [ppmenc_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [COL_W-1:0]                    column_count_ff, column_count_in;
   logic [ppmenc_pkg::CHAR_W-1:0]       row_char_count_ff, row_char_count_in;
   logic [ppmenc_pkg::BREAK_W-1:0]      break_count_ff, break_count_in;

   logic [30:0]                         scaled;
   logic [14:0]                         rounded;
   logic [7:0]                          level;
   logic [1:0]                          num_digits;
   logic [WID_W-1:0]                    eff_width;
   logic [WID_W-1:0]                    col_next;
   logic [ppmenc_pkg::LINE_LIMIT_W-1:0] eff_limit;
   logic [ppmenc_pkg::BREAK_W:0]        break_plus_one;
   logic [18:0]                         threshold;
   logic [ppmenc_pkg::CHAR_W:0]         char_sum;
   logic                                row_end;
   logic                                newline;

   assign req_ready = q_status.not_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      scaled  = 31'(req_component[22:0]) * 31'(255) + 31'(32768);
      rounded = scaled[30:16];
      if (req_component[23]) begin
         level = 8'd0;
      end else if (rounded > 15'd255) begin
         level = 8'd255;
      end else begin
         level = rounded[7:0];
      end
      if (level >= 8'd100) begin
         num_digits = 2'd3;
      end else if (level >= 8'd10) begin
         num_digits = 2'd2;
      end else begin
         num_digits = 2'd1;
      end
   end

   always_comb begin
      if (row_width_ff == '0) begin
         eff_width = WID_W'(1);
      end else if (WID_W'(row_width_ff) > WID_W'(MAX_WIDTH)) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(row_width_ff);
      end
      col_next  = WID_W'(column_count_ff) + WID_W'(1);
      row_end   = (slot_ff == ppmenc_pkg::SLOT_BLUE) && (col_next >= eff_width);
      eff_limit = (line_limit_ff == '0) ? 8'd1 : line_limit_ff;
      break_plus_one = {1'b0, break_count_ff} + 11'd1;
      threshold = 19'(break_plus_one) * 19'(eff_limit);
      newline   = (19'(row_char_count_ff) >= threshold) || row_end;
      char_sum  = {1'b0, row_char_count_ff} + 17'(num_digits) + 17'd1;
   end

   always_comb begin
      row_width_in  = row_width_ff;
      line_limit_in = line_limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ppmenc_pkg::CSR_ROW_WIDTH: begin
               row_width_in = csr_write_data;
            end
            ppmenc_pkg::CSR_LINE_LIMIT: begin
               line_limit_in = csr_write_data[ppmenc_pkg::LINE_LIMIT_W-1:0];
            end
            default: begin
               row_width_in = row_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      slot_in           = slot_ff;
      column_count_in   = column_count_ff;
      row_char_count_in = row_char_count_ff;
      break_count_in    = break_count_ff;
      if (push) begin
         if (newline && (break_count_ff != ppmenc_pkg::BREAK_SAT)) begin
            break_count_in = break_count_ff + 10'd1;
         end
         if (char_sum[ppmenc_pkg::CHAR_W]) begin
            row_char_count_in = ppmenc_pkg::CHAR_SAT;
         end else begin
            row_char_count_in = char_sum[ppmenc_pkg::CHAR_W-1:0];
         end
         if (slot_ff >= ppmenc_pkg::SLOT_BLUE) begin
            slot_in = ppmenc_pkg::SLOT_RED;
            if (row_end) begin
               column_count_in   = '0;
               row_char_count_in = '0;
               break_count_in    = '0;
            end else begin
               column_count_in = column_count_ff + COL_W'(1);
            end
         end else begin
            slot_in = slot_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff      <= ppmenc_pkg::ROW_WIDTH_RESET;
         line_limit_ff     <= ppmenc_pkg::LINE_LIMIT_RESET;
         slot_ff           <= ppmenc_pkg::SLOT_RED;
         column_count_ff   <= '0;
         row_char_count_ff <= '0;
         break_count_ff    <= '0;
      end else begin
         row_width_ff      <= row_width_in;
         line_limit_ff     <= line_limit_in;
         slot_ff           <= slot_in;
         column_count_ff   <= column_count_in;
         row_char_count_ff <= row_char_count_in;
         break_count_ff    <= break_count_in;
      end
   end

   assign push_entry.level   = level;
   assign push_entry.newline = newline;

endmodule

FILE: rtl/ppmenc_queue.sv
module ppmenc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ppmenc_pkg::queue_entry_type   push_entry,
   input  logic                          pop,
   output ppmenc_pkg::queue_entry_type   head,
   output ppmenc_pkg::queue_status_type  status
);

   ppmenc_pkg::queue_entry_type             entries_ff [ppmenc_pkg::Q_DEPTH];
   logic [ppmenc_pkg::Q_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [ppmenc_pkg::Q_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [ppmenc_pkg::Q_CNT_W-1:0]          count_ff, count_in;

   localparam logic [ppmenc_pkg::Q_PTR_W-1:0] LAST_PTR =
      ppmenc_pkg::Q_PTR_W'(ppmenc_pkg::Q_DEPTH - 1);
   localparam logic [ppmenc_pkg::Q_CNT_W-1:0] FULL_COUNT =
      ppmenc_pkg::Q_CNT_W'(ppmenc_pkg::Q_DEPTH);

   assign status.not_full  = (count_ff != FULL_COUNT);
   assign status.not_empty = (count_ff != '0);
   assign head             = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> status.not_full)
      else $error("Request written into a full queue.");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("Entry taken from an empty queue.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Queue count beyond its depth.");

endmodule

FILE: rtl/ppmenc_back.sv
module ppmenc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ppmenc_pkg::queue_entry_type   head,
   input  ppmenc_pkg::queue_status_type  q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_text_byte,
   output logic                          rsp_last_of_item
);

   logic [31:0] bytes_ff, bytes_in;
   logic [2:0]  count_ff, count_in;

   logic [1:0]  hundreds;
   logic [6:0]  rest;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  ones_wide;
   logic [3:0]  ones;
   logic [7:0]  sep_byte;
   logic [7:0]  h_byte;
   logic [7:0]  t_byte;
   logic [7:0]  o_byte;
   logic        fire;

   assign fire             = rsp_valid && rsp_ready;
   assign rsp_valid        = (count_ff != 3'd0);
   assign rsp_text_byte    = bytes_ff[7:0];
   assign rsp_last_of_item = (count_ff == 3'd1);
   assign pop = q_status.not_empty && ((count_ff == 3'd0) || ((count_ff == 3'd1) && rsp_ready));

   always_comb begin
      if (head.level >= 8'd200) begin
         hundreds = 2'd2;
      end else if (head.level >= 8'd100) begin
         hundreds = 2'd1;
      end else begin
         hundreds = 2'd0;
      end
      rest      = 7'(head.level - 8'(hundreds) * 8'd100);
      tens_prod = 15'(rest) * 15'd205;
      tens      = tens_prod[14:11];
      ones_wide = rest - 7'(tens) * 7'd10;
      ones      = ones_wide[3:0];
      sep_byte  = head.newline ? ppmenc_pkg::BYTE_NEWLINE : ppmenc_pkg::BYTE_SPACE;
      h_byte    = ppmenc_pkg::BYTE_ZERO + 8'(hundreds);
      t_byte    = ppmenc_pkg::BYTE_ZERO + 8'(tens);
      o_byte    = ppmenc_pkg::BYTE_ZERO + 8'(ones);
   end

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (pop) begin
         if (head.level >= 8'd100) begin
            bytes_in = {sep_byte, o_byte, t_byte, h_byte};
            count_in = 3'd4;
         end else if (head.level >= 8'd10) begin
            bytes_in = {8'h00, sep_byte, o_byte, t_byte};
            count_in = 3'd3;
         end else begin
            bytes_in = {16'h0000, sep_byte, o_byte};
            count_in = 3'd2;
         end
      end else if (fire) begin
         bytes_in = {8'h00, bytes_ff[31:8]};
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_item) |->
         (rsp_text_byte == ppmenc_pkg::BYTE_SPACE ||
          rsp_text_byte == ppmenc_pkg::BYTE_NEWLINE))
      else $error("Final byte of a component is not a separator.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_item) |->
         (rsp_text_byte >= ppmenc_pkg::BYTE_ZERO && rsp_text_byte <= ppmenc_pkg::BYTE_NINE))
      else $error("Non-final byte of a component is not a decimal digit.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("More than four bytes pending for one component.");

endmodule

FILE: rtl/plain_ppm_pixel_text_encoder.sv
// Converts a stream of signed Q8.16 colour components (red, green, blue, pixel by pixel)
// into plain PPM body text: each component becomes one to three decimal digits and a
// separator byte, space or newline, and each byte is one response. A request is accepted
// whenever the two-entry queue between the classifying front end and the serialising back
// end has room, so requests may arrive on consecutive cycles; a component then occupies
// the output for two to four bytes, one byte per cycle while rsp_ready is high, which
// sets the sustained rate. Entries pass the queue, then the byte register. Configuration
// writes take effect on the next cycle and must only be made while the block is idle.
module plain_ppm_pixel_text_encoder #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ppmenc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ppmenc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ppmenc_pkg::COMP_W-1:0]  req_component,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_text_byte,
   output logic                                  rsp_last_of_item
);

   ppmenc_pkg::queue_status_type q_status;
   ppmenc_pkg::queue_entry_type  push_entry;
   ppmenc_pkg::queue_entry_type  head;
   logic                         push;
   logic                         pop;

   ppmenc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_component    (req_component),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   ppmenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   ppmenc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule
